// ----- src/tbcr_pkg.sv -----
// Shared constants, types and helpers of the two-body collision response core.
// Used by the top level and the pipelined divider.
`default_nettype none

package tbcr_pkg;

  localparam int unsigned REST_W = 17;
  localparam int unsigned REST_FRAC = 16;
  localparam logic [REST_W-1:0] REST_RESET = 17'h10000;

  // 4295 / 2^32 is one millionth.
  localparam logic [12:0] EPS_Q32 = 13'd4295;

  // Normalized offsets have their top bit at this position.
  localparam int unsigned NORM_TOP = 28;

  localparam int unsigned DIV_STEPS = 35;
  localparam int unsigned DEN_W = 59;
  localparam int unsigned NUM_W = 92;

  localparam int unsigned FRONT = 9;
  localparam int unsigned BACK = 6;
  localparam int unsigned CARRY_LEN = FRONT + DIV_STEPS + BACK;
  localparam int unsigned LANES = 4;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic               xneg;
    logic               yneg;
    logic               pneg;
    logic               approach;
    logic               mzero;
  } carry_t;

  function automatic logic [31:0] sat32(input logic signed [40:0] x);
    logic [31:0] r;
    if (x > 41'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -41'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/tbcr_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on tbcr_pkg for its widths and step count.
`default_nettype none

module tbcr_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [tbcr_pkg::NUM_W-1:0]      num_i,
  input  logic [tbcr_pkg::DEN_W-1:0]      den_i,
  output logic [tbcr_pkg::DIV_STEPS-1:0]  quo_o
);
  import tbcr_pkg::*;

  logic [DEN_W-1:0]     rem_in [DIV_STEPS];
  logic [DEN_W-1:0]     den_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_in [DIV_STEPS];

  logic [DEN_W-1:0]     rem_d [DIV_STEPS];
  logic [DEN_W-1:0]     rem_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];
  logic [DEN_W-1:0]     den_q [DIV_STEPS];

  always_comb begin
    rem_in[0] = DEN_W'(num_i[NUM_W-1:DIV_STEPS]);
    low_in[0] = num_i[DIV_STEPS-1:0];
    quo_in[0] = '0;
    den_in[0] = den_i;
    for (int j = 1; j < DIV_STEPS; j++) begin
      rem_in[j] = rem_q[j-1];
      low_in[j] = low_q[j-1];
      quo_in[j] = quo_q[j-1];
      den_in[j] = den_q[j-1];
    end
  end

  always_comb begin
    logic [DEN_W:0] trial;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = {rem_in[j], low_in[j][DIV_STEPS-1]};
      if (trial >= {1'b0, den_in[j]}) begin
        rem_d[j] = DEN_W'(trial - {1'b0, den_in[j]});
        quo_d[j] = {quo_in[j][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d[j] = trial[DEN_W-1:0];
        quo_d[j] = {quo_in[j][DIV_STEPS-2:0], 1'b0};
      end
      low_d[j] = {low_in[j][DIV_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      low_q <= low_d;
      quo_q <= quo_d;
      den_q <= den_in;
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- src/two_body_collision_response_core.sv -----
// Top level of the two-body collision response core: a single stallable pipeline.
// Depends on tbcr_pkg and instantiates three tbcr_div dividers.
`default_nettype none

// The core takes one body pair per clock while it is not stalled and returns one
// result per pair, in order. Most of the pipeline depth lies in the three
// 35-stage restoring dividers (mass share and the two impulse terms), which run
// side by side between a nine-stage front end and a seven-stage back end. The
// whole pipeline advances together; it holds only while a result waits at the
// output and out_stall_i is high, and in_stall_o is raised exactly then.
// The restitution register is written through cfg_we_i and cfg_wdata_i and must
// only be changed while no transaction is in flight.
module two_body_collision_response_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tbcr_pkg::REST_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   mass_a_i,
  input  logic [31:0]                   mass_b_i,
  input  logic signed [31:0]            pos_ax_i,
  input  logic signed [31:0]            pos_ay_i,
  input  logic signed [31:0]            pos_bx_i,
  input  logic signed [31:0]            pos_by_i,
  input  logic signed [31:0]            vel_ax_i,
  input  logic signed [31:0]            vel_ay_i,
  input  logic signed [31:0]            vel_bx_i,
  input  logic signed [31:0]            vel_by_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_vel_ax_o,
  output logic signed [31:0]            new_vel_ay_o,
  output logic signed [31:0]            new_vel_bx_o,
  output logic signed [31:0]            new_vel_by_o,
  output logic                          collided_o
);
  import tbcr_pkg::*;

  localparam int unsigned ST_APPROACH = 4;
  localparam int unsigned ST_PNEG = 6;
  localparam int unsigned ST_DIV = FRONT + DIV_STEPS - 1;

  logic adv;
  logic [CARRY_LEN:0] vld_q;
  logic [REST_W-1:0] rest_q;

  carry_t carry0_d;
  carry_t c_d [CARRY_LEN];
  carry_t c_q [CARRY_LEN];

  logic [31:0] ma_q [FRONT];
  logic [32:0] msum_q [FRONT];

  // Front end.
  logic signed [32:0] dx0, dy0;
  logic [32:0] mx0_d, my0_d, mx0_q, my0_q;
  logic [32:0] mx1_q, my1_q;
  logic [5:0]  top1_d, top1_q;
  logic [28:0] mx2_d, my2_d, mx2_q, my2_q;
  logic signed [29:0] nxs3, nys3;
  logic signed [62:0] prx3_d, pry3_d, prx3_q, pry3_q;
  logic [41:0] fyp3;
  logic [9:0]  fy3_q;
  logic [28:0] mx3_q, my3_q;
  logic signed [63:0] dot4;
  logic [28:0] mxc4_d, mxc4_q, my4_q;
  logic signed [62:0] pry4_q;
  logic signed [29:0] nxc5;
  logic signed [62:0] prxc5_d, prxc5_q, pry5_q;
  logic [57:0] sqx5_q, sqy5_q;
  logic [28:0] mx5_q, my5_q;
  logic signed [63:0] dot6, pmag6;
  logic [62:0] tp6_q;
  logic [DEN_W-1:0] d2_6_q, d2_7_q, d2_8_q;
  logic [28:0] mx6_q, my6_q;
  logic [60:0] pxl7_q, pyl7_q;
  logic [59:0] pxh7_q, pyh7_q;
  logic [NUM_W-1:0] numx8_q, numy8_q;

  logic [DIV_STEPS-1:0] gx_w, gy_w, wq_w;

  // Back end.
  logic [32:0] w44_d, w44_q, wb44_q, dvmx44_q, dvmy44_q;
  logic [DIV_STEPS-1:0] gx44_q, gy44_q;
  logic [64:0] pbxl_q, pbyl_q, paxl_q, payl_q;
  logic [35:0] pbxh_q, pbyh_q, paxh_q, payh_q;
  logic [65:0] pcx_q, pcy_q;
  logic [36:0] dax46_q, day46_q, dbx46_q, dby46_q;
  logic [33:0] cdx46_q, cdy46_q;

  logic signed [40:0] nv47_d [LANES];
  logic signed [40:0] nv47_q [LANES];
  logic signed [40:0] cm47_d [LANES];
  logic signed [40:0] cm47_q [LANES];
  logic [37:0] dm48_d [LANES];
  logic [37:0] dm48_q [LANES];
  logic        dn48_d [LANES];
  logic        dn48_q [LANES];
  logic signed [40:0] cm48_q [LANES];
  logic [38:0] s49_d [LANES];
  logic [38:0] s49_q [LANES];
  logic        dn49_q [LANES];
  logic signed [40:0] cm49_q [LANES];
  logic [31:0] res_d [LANES];
  logic [31:0] res_q [LANES];
  logic        col_q;

  assign adv = !vld_q[CARRY_LEN] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rest_q <= REST_RESET;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[CARRY_LEN-1:0], in_valid_i};
      end
      if (cfg_we_i) begin
        rest_q <= cfg_wdata_i;
      end
    end
  end

  // Stage 0: offsets and relative velocity.
  always_comb begin
    dx0 = {pos_bx_i[31], pos_bx_i} - {pos_ax_i[31], pos_ax_i};
    dy0 = {pos_by_i[31], pos_by_i} - {pos_ay_i[31], pos_ay_i};
    mx0_d = dx0[32] ? 33'(-dx0) : 33'(dx0);
    my0_d = dy0[32] ? 33'(-dy0) : 33'(dy0);
    carry0_d.vax = vel_ax_i;
    carry0_d.vay = vel_ay_i;
    carry0_d.vbx = vel_bx_i;
    carry0_d.vby = vel_by_i;
    carry0_d.dvx = {vel_bx_i[31], vel_bx_i} - {vel_ax_i[31], vel_ax_i};
    carry0_d.dvy = {vel_by_i[31], vel_by_i} - {vel_ay_i[31], vel_ay_i};
    carry0_d.xneg = dx0[32];
    carry0_d.yneg = dy0[32];
    carry0_d.pneg = 1'b0;
    carry0_d.approach = 1'b0;
    carry0_d.mzero = (mass_a_i == 32'd0) && (mass_b_i == 32'd0);
  end

  always_comb begin
    c_d[0] = carry0_d;
    for (int k = 1; k < CARRY_LEN; k++) begin
      c_d[k] = c_q[k-1];
    end
    c_d[ST_APPROACH].approach = dot4[63];
    c_d[ST_PNEG].pneg = dot6[63];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q <= c_d;
      ma_q[0] <= mass_a_i;
      msum_q[0] <= {1'b0, mass_a_i} + {1'b0, mass_b_i};
      for (int k = 1; k < FRONT; k++) begin
        ma_q[k] <= ma_q[k-1];
        msum_q[k] <= msum_q[k-1];
      end
    end
  end

  // Stage 1: position of the leading one of the larger offset.
  always_comb begin
    logic [32:0] m;
    m = (mx0_q > my0_q) ? mx0_q : my0_q;
    top1_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) begin
        top1_d = 6'(i);
      end
    end
  end

  // Stage 2: normalize both offsets by the same shift.
  always_comb begin
    if (top1_q > 6'(NORM_TOP)) begin
      mx2_d = 29'(mx1_q >> (top1_q - 6'(NORM_TOP)));
      my2_d = 29'(my1_q >> (top1_q - 6'(NORM_TOP)));
    end else begin
      mx2_d = 29'(mx1_q << (6'(NORM_TOP) - top1_q));
      my2_d = 29'(my1_q << (6'(NORM_TOP) - top1_q));
    end
  end

  // Stage 3: projections for the approach test and the x clamp floor.
  always_comb begin
    nxs3 = c_q[2].xneg ? -$signed({1'b0, mx2_q}) : $signed({1'b0, mx2_q});
    nys3 = c_q[2].yneg ? -$signed({1'b0, my2_q}) : $signed({1'b0, my2_q});
    prx3_d = $signed(c_q[2].dvx) * nxs3;
    pry3_d = $signed(c_q[2].dvy) * nys3;
    fyp3 = {13'd0, my2_q} * {29'd0, EPS_Q32};
  end

  // Stage 4: approach test and clamp of the x component.
  always_comb begin
    dot4 = 64'(prx3_q) + 64'(pry3_q);
    mxc4_d = (mx3_q < 29'(fy3_q)) ? 29'(fy3_q) : mx3_q;
  end

  // Stage 5: projection with the clamped normal and its squared length terms.
  always_comb begin
    nxc5 = c_q[4].xneg ? -$signed({1'b0, mxc4_q}) : $signed({1'b0, mxc4_q});
    prxc5_d = $signed(c_q[4].dvx) * nxc5;
  end

  // Stage 6: final dot product, its magnitude and the squared length.
  always_comb begin
    dot6 = 64'(prxc5_q) + 64'(pry5_q);
    pmag6 = dot6[63] ? -dot6 : dot6;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx0_q <= mx0_d;
      my0_q <= my0_d;
      mx1_q <= mx0_q;
      my1_q <= my0_q;
      top1_q <= top1_d;
      mx2_q <= mx2_d;
      my2_q <= my2_d;
      prx3_q <= prx3_d;
      pry3_q <= pry3_d;
      fy3_q <= fyp3[41:32];
      mx3_q <= mx2_q;
      my3_q <= my2_q;
      mxc4_q <= mxc4_d;
      my4_q <= my3_q;
      pry4_q <= pry3_q;
      prxc5_q <= prxc5_d;
      pry5_q <= pry4_q;
      sqx5_q <= 58'(mxc4_q) * 58'(mxc4_q);
      sqy5_q <= 58'(my4_q) * 58'(my4_q);
      mx5_q <= mxc4_q;
      my5_q <= my4_q;
      tp6_q <= {pmag6[61:0], 1'b0};
      d2_6_q <= DEN_W'(sqx5_q) + DEN_W'(sqy5_q);
      mx6_q <= mx5_q;
      my6_q <= my5_q;
      pxl7_q <= 61'(tp6_q[31:0]) * 61'(mx6_q);
      pxh7_q <= 60'(tp6_q[62:32]) * 60'(mx6_q);
      pyl7_q <= 61'(tp6_q[31:0]) * 61'(my6_q);
      pyh7_q <= 60'(tp6_q[62:32]) * 60'(my6_q);
      d2_7_q <= d2_6_q;
      numx8_q <= {pxh7_q, 32'd0} + NUM_W'(pxl7_q);
      numy8_q <= {pyh7_q, 32'd0} + NUM_W'(pyl7_q);
      d2_8_q <= d2_7_q;
    end
  end

  tbcr_div u_div_gx (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx8_q),
    .den_i (d2_8_q),
    .quo_o (gx_w)
  );

  tbcr_div u_div_gy (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy8_q),
    .den_i (d2_8_q),
    .quo_o (gy_w)
  );

  tbcr_div u_div_w (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (NUM_W'({ma_q[FRONT-1], 32'd0})),
    .den_i (DEN_W'(msum_q[FRONT-1])),
    .quo_o (wq_w)
  );

  assign w44_d = c_q[ST_DIV].mzero ? 33'h0_8000_0000 : wq_w[32:0];

  // Stage 47: updated velocities and centre-of-mass velocity per lane.
  always_comb begin
    carry_t cr;
    logic ax_neg, ay_neg;
    logic signed [40:0] dlt, cmx, cmy;
    logic [36:0] dm [LANES];
    logic dn [LANES];
    logic signed [31:0] vin [LANES];
    cr = c_q[ST_DIV+3];
    ax_neg = cr.pneg ^ cr.xneg;
    ay_neg = cr.pneg ^ cr.yneg;
    vin[0] = cr.vax;
    vin[1] = cr.vay;
    vin[2] = cr.vbx;
    vin[3] = cr.vby;
    dm[0] = dax46_q;
    dm[1] = day46_q;
    dm[2] = dbx46_q;
    dm[3] = dby46_q;
    dn[0] = ax_neg;
    dn[1] = ay_neg;
    dn[2] = !ax_neg;
    dn[3] = !ay_neg;
    dlt = $signed({7'd0, cdx46_q});
    cmx = 41'($signed(cr.vax)) + (cr.dvx[32] ? -dlt : dlt);
    dlt = $signed({7'd0, cdy46_q});
    cmy = 41'($signed(cr.vay)) + (cr.dvy[32] ? -dlt : dlt);
    for (int l = 0; l < LANES; l++) begin
      dlt = $signed({4'd0, dm[l]});
      nv47_d[l] = 41'($signed(vin[l])) + (dn[l] ? -dlt : dlt);
      cm47_d[l] = l[0] ? cmy : cmx;
    end
  end

  // Stage 48: deviation from the centre-of-mass velocity.
  always_comb begin
    logic signed [40:0] dev;
    for (int l = 0; l < LANES; l++) begin
      dev = nv47_q[l] - cm47_q[l];
      dn48_d[l] = dev[40];
      dm48_d[l] = dev[40] ? 38'(-dev) : 38'(dev);
    end
  end

  // Stage 49: restitution scaling.
  always_comb begin
    logic [54:0] prod;
    for (int l = 0; l < LANES; l++) begin
      prod = 55'(dm48_q[l]) * 55'(rest_q);
      s49_d[l] = 39'(prod >> REST_FRAC);
    end
  end

  // Stage 50: recombine, saturate and select.
  always_comb begin
    logic signed [40:0] sv, r;
    logic [31:0] vin [LANES];
    vin[0] = c_q[CARRY_LEN-1].vax;
    vin[1] = c_q[CARRY_LEN-1].vay;
    vin[2] = c_q[CARRY_LEN-1].vbx;
    vin[3] = c_q[CARRY_LEN-1].vby;
    for (int l = 0; l < LANES; l++) begin
      sv = $signed({2'd0, s49_q[l]});
      r = cm49_q[l] + (dn49_q[l] ? -sv : sv);
      res_d[l] = c_q[CARRY_LEN-1].approach ? sat32(r) : vin[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w44_q <= w44_d;
      wb44_q <= 33'h1_0000_0000 - w44_d;
      gx44_q <= gx_w;
      gy44_q <= gy_w;
      dvmx44_q <= c_q[ST_DIV].dvx[32] ? 33'(-c_q[ST_DIV].dvx) : 33'(c_q[ST_DIV].dvx);
      dvmy44_q <= c_q[ST_DIV].dvy[32] ? 33'(-c_q[ST_DIV].dvy) : 33'(c_q[ST_DIV].dvy);
      pbxl_q <= 65'(gx44_q[31:0]) * 65'(w44_q);
      pbxh_q <= 36'(gx44_q[DIV_STEPS-1:32]) * 36'(w44_q);
      pbyl_q <= 65'(gy44_q[31:0]) * 65'(w44_q);
      pbyh_q <= 36'(gy44_q[DIV_STEPS-1:32]) * 36'(w44_q);
      paxl_q <= 65'(gx44_q[31:0]) * 65'(wb44_q);
      paxh_q <= 36'(gx44_q[DIV_STEPS-1:32]) * 36'(wb44_q);
      payl_q <= 65'(gy44_q[31:0]) * 65'(wb44_q);
      payh_q <= 36'(gy44_q[DIV_STEPS-1:32]) * 36'(wb44_q);
      pcx_q <= 66'(dvmx44_q) * 66'(wb44_q);
      pcy_q <= 66'(dvmy44_q) * 66'(wb44_q);
      dbx46_q <= 37'(pbxh_q) + 37'(pbxl_q[64:32]);
      dby46_q <= 37'(pbyh_q) + 37'(pbyl_q[64:32]);
      dax46_q <= 37'(paxh_q) + 37'(paxl_q[64:32]);
      day46_q <= 37'(payh_q) + 37'(payl_q[64:32]);
      cdx46_q <= pcx_q[65:32];
      cdy46_q <= pcy_q[65:32];
      nv47_q <= nv47_d;
      cm47_q <= cm47_d;
      dm48_q <= dm48_d;
      dn48_q <= dn48_d;
      cm48_q <= cm47_q;
      s49_q <= s49_d;
      dn49_q <= dn48_q;
      cm49_q <= cm48_q;
      res_q <= res_d;
      col_q <= c_q[CARRY_LEN-1].approach;
    end
  end

  assign out_valid_o  = vld_q[CARRY_LEN];
  assign new_vel_ax_o = res_q[0];
  assign new_vel_ay_o = res_q[1];
  assign new_vel_bx_o = res_q[2];
  assign new_vel_by_o = res_q[3];
  assign collided_o   = col_q;

endmodule

`default_nettype wire

// ----- src/tbcr_chk.sv -----
// Port checker for the two-body collision response core, bound to its top level.
// Depends only on the handshake and result ports of the top level.
`default_nettype none

module tbcr_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [31:0]            new_vel_ax_o,
  input logic signed [31:0]            new_vel_ay_o,
  input logic signed [31:0]            new_vel_bx_o,
  input logic signed [31:0]            new_vel_by_o,
  input logic                          collided_o
);

  // A held result transaction keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_vel_ax_o) &&
      $stable(new_vel_ay_o) && $stable(new_vel_bx_o) && $stable(new_vel_by_o) &&
      $stable(collided_o))
    else $error("held result transaction changed");

  // The input side is held back only by a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A waiting result freezes the whole pipeline, input included.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("pipeline advanced while a result was held");

endmodule

bind two_body_collision_response_core tbcr_chk u_tbcr_chk (.*);

`default_nettype wire
